// ----- hdl/psdm_pkg.sv -----
// Shared constants, types and modular helpers for the power series divider.
`timescale 1ns / 1ps
`default_nettype none

package psdm_pkg;

  localparam int DEPTH   = 4096;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int RES_W   = 30;
  localparam int INDEX_W = 12;
  localparam int MU_W    = RES_W + 1;
  // wide enough for the Barrett remainder before correction, below 3p
  localparam int BAR_W   = RES_W + 2;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 48;

  localparam logic [RES_W-1:0] PRIME    = RES_W'(998244353);
  localparam logic [BAR_W-1:0] PRIME_1X = {2'b00, PRIME};
  localparam logic [BAR_W-1:0] PRIME_2X = {1'b0, PRIME, 1'b0};
  // floor(2^60 / p), reciprocal for the quotient estimate
  localparam logic [MU_W-1:0]  BARRETT_MU = MU_W'((64'd1 << (2 * RES_W)) / 64'(PRIME));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ovf_now;
    logic k_zero;
    logic last_issue;
    logic pipe_busy;
  } dp_status_t;

  // One conditional subtract; valid for any input below twice the prime.
  function automatic logic [RES_W-1:0] mod_fold(input logic [RES_W:0] x);
    logic [RES_W:0] d;
    d = x - {1'b0, PRIME};
    if (x >= {1'b0, PRIME}) begin
      return d[RES_W-1:0];
    end
    return x[RES_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/power_series_division_mod_prime_top.sv -----
// Top level of the power series divider modulo 998244353.
`timescale 1ns / 1ps
`default_nettype none

// Each input word carries a[k] and b[k]; the block returns d[k] = a[k] - sum of b[i]*d[k-i]
// for i = 1..k, modulo 998244353, with b[0] taken as 1. restart (tuser) makes the word
// index 0. Indices run to 4095; past that a word without restart returns overflow with
// zero fields and changes nothing. One word is worked at a time: for index k the single
// multiplier steps over the two coefficient stores (one read each per cycle) for i = 1..k,
// then the product and Barrett reduction pipe drains and the result is formed; index 0 and
// overflow words skip straight to the result. The input is ready again in the same cycle
// as the result is presented, so a new word is not taken until the last one is finished.
// A finished result sits in the output register while the next word is taken in; a
// result still waiting there holds up the following one.
module power_series_division_mod_prime_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [psdm_pkg::S_TDATA_W-1:0] s_tdata,  // num_coeff[29:0], den_coeff[59:30]
  input  wire logic                           s_tuser,  // restart
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [psdm_pkg::M_TDATA_W-1:0] m_tdata,  // quot_coeff[29:0], coeff_index[41:30]
  output logic                                m_tuser   // overflow
);
  import psdm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  psdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psdm_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

`default_nettype wire

// ----- hdl/psdm_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module psdm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/psdm_ctrl.sv -----
// Controller state machine: sequences load, multiply-accumulate, drain and result.
`timescale 1ns / 1ps
`default_nettype none

module psdm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire psdm_pkg::dp_status_t status,
  output psdm_pkg::ctrl_cmd_t       cmd
);
  import psdm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          // nothing to sum for index 0 or an overflow word
          if (status.ovf_now || status.k_zero) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("result not presented after finish");

  a_no_load_during_work: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !s_tready)
    else $error("input taken while an item is in progress");

  a_issue_follows_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !status.ovf_now && !status.k_zero) |=> cmd.issue)
    else $error("multiply-accumulate did not start after load");

endmodule

`default_nettype wire

// ----- hdl/psdm_dp.sv -----
// Datapath: coefficient stores, multiply-accumulate pipe with Barrett reduction, result register.
`timescale 1ns / 1ps
`default_nettype none

module psdm_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [psdm_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic                              s_tuser,
  output logic      [psdm_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                   m_tuser,
  input  wire psdm_pkg::ctrl_cmd_t               cmd,
  output psdm_pkg::dp_status_t                   status
);
  import psdm_pkg::*;

  logic [RES_W-1:0]       num_in;
  logic [RES_W-1:0]       den_in;
  logic [CNT_W-1:0]       eff_k;
  logic                   ovf_now;

  logic [CNT_W-1:0]       next_index;
  logic [CNT_W-1:0]       k;
  logic [CNT_W-1:0]       i;
  logic                   ovf;
  logic [RES_W-1:0]       num;
  logic                   rd_v;
  logic                   prod_v;
  logic                   bar_v;
  logic                   sub_v;
  logic                   red_v;
  logic [2*RES_W-1:0]     prod;
  logic [MU_W-1:0]        bar_q;
  logic [BAR_W-1:0]       prod_lo;
  logic [BAR_W-1:0]       bar_r;
  logic [RES_W-1:0]       red;
  logic [RES_W-1:0]       acc;
  logic [2*MU_W-1:0]      bar_est;
  logic [MU_W+RES_W-1:0]  bar_qp;

  logic [RES_W-1:0]       den_rd;
  logic [RES_W-1:0]       quot_rd;
  logic [CNT_W-1:0]       quot_addr;
  logic [RES_W-1:0]       q;
  logic [RES_W:0]         q_diff;

  logic [RES_W-1:0]       out_quot;
  logic [INDEX_W-1:0]     out_index;

  assign num_in  = mod_fold({1'b0, s_tdata[RES_W-1:0]});
  assign den_in  = mod_fold({1'b0, s_tdata[2*RES_W-1:RES_W]});
  assign eff_k   = s_tuser ? '0 : next_index;
  assign ovf_now = eff_k >= CNT_W'(DEPTH);

  assign quot_addr = k - i;

  // Barrett: quotient estimate from the top 31 product bits, remainder below 3p
  assign bar_est = prod[2*RES_W-1:RES_W-1] * BARRETT_MU;
  assign bar_qp  = bar_q * PRIME;

  // q = num - acc mod p
  assign q_diff = {1'b0, num} + {1'b0, PRIME} - {1'b0, acc};
  assign q      = mod_fold(q_diff);

  psdm_ram #(.WIDTH(RES_W), .DEPTH(DEPTH)) u_den_store (
    .clk     (clk),
    .wr_en   (cmd.load && !ovf_now),
    .wr_addr (eff_k[ADDR_W-1:0]),
    .wr_data (den_in),
    .rd_en   (cmd.issue),
    .rd_addr (i[ADDR_W-1:0]),
    .rd_data (den_rd)
  );

  psdm_ram #(.WIDTH(RES_W), .DEPTH(DEPTH)) u_quot_store (
    .clk     (clk),
    .wr_en   (cmd.finish && !ovf),
    .wr_addr (k[ADDR_W-1:0]),
    .wr_data (q),
    .rd_en   (cmd.issue),
    .rd_addr (quot_addr[ADDR_W-1:0]),
    .rd_data (quot_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index <= '0;
      rd_v       <= 1'b0;
      prod_v     <= 1'b0;
      bar_v      <= 1'b0;
      sub_v      <= 1'b0;
      red_v      <= 1'b0;
      acc        <= '0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
      bar_v  <= prod_v;
      sub_v  <= bar_v;
      red_v  <= sub_v;
      if (cmd.load) begin
        acc <= '0;
      end else if (red_v) begin
        acc <= mod_fold({1'b0, acc} + {1'b0, red});
      end
      if (cmd.finish && !ovf) begin
        next_index <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k   <= eff_k;
      ovf <= ovf_now;
      num <= num_in;
      i   <= CNT_W'(1);
    end else if (cmd.issue) begin
      i <= i + 1'b1;
    end
    if (rd_v) begin
      prod <= den_rd * quot_rd;
    end
    if (prod_v) begin
      bar_q   <= bar_est[2*MU_W-1:RES_W+1];
      prod_lo <= prod[BAR_W-1:0];
    end
    if (bar_v) begin
      bar_r <= prod_lo - bar_qp[BAR_W-1:0];
    end
    if (sub_v) begin
      if (bar_r >= PRIME_2X) begin
        red <= RES_W'(bar_r - PRIME_2X);
      end else if (bar_r >= PRIME_1X) begin
        red <= RES_W'(bar_r - PRIME_1X);
      end else begin
        red <= bar_r[RES_W-1:0];
      end
    end
    if (cmd.finish) begin
      out_quot  <= ovf ? '0 : q;
      out_index <= ovf ? '0 : INDEX_W'(k);
      m_tuser   <= ovf;
    end
  end

  assign m_tdata = {{(M_TDATA_W - RES_W - INDEX_W){1'b0}}, out_index, out_quot};

  always_comb begin
    status            = '0;
    status.ovf_now    = ovf_now;
    status.k_zero     = eff_k == '0;
    status.last_issue = i == k;
    status.pipe_busy  = rd_v || prod_v || bar_v || sub_v || red_v;
  end

  a_pipe_empty_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(rd_v || prod_v || bar_v || sub_v || red_v))
    else $error("new word accepted with products still in flight");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    acc < PRIME)
    else $error("accumulator not below the prime");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    next_index <= CNT_W'(DEPTH))
    else $error("next index passed the store depth");

endmodule

`default_nettype wire
